// File: sv/matrix_inverse_3x3_top_defines.svh
// Assertion macros for the 3x3 matrix inverse block.
`ifndef MATRIX_INVERSE_3X3_TOP_DEFINES_SVH
`define MATRIX_INVERSE_3X3_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MI3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MI3_ASSERT_NOW(lbl, ante, cons, msg)
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/mi3_pkg.sv
// Shared constants, widths and types for the 3x3 matrix inverse block.
`default_nettype none
package mi3_pkg;
  localparam int FRAC_BITS  = 16;
  localparam int ELEM_WIDTH = 32;
  localparam int FIELD_W    = 32;
  localparam int N_ELEM     = 9;

  localparam int PROD_W  = 2 * ELEM_WIDTH;
  localparam int COF_W   = 2 * ELEM_WIDTH + 1;
  localparam int DPROD_W = 3 * ELEM_WIDTH + 1;
  localparam int DET_W   = 3 * ELEM_WIDTH + 3;
  localparam int NUM_W   = COF_W + 2 * FRAC_BITS;
  localparam int QUO_W   = ELEM_WIDTH - 1;
  localparam int REM_W   = DET_W;
  localparam int HI_W    = NUM_W - QUO_W;

  localparam int FRONT_ST = 6;
  localparam int LANE_ST  = 2 + QUO_W;
  localparam int PIPE_ST  = FRONT_ST + LANE_ST + 1;

  // 1.0 in fixed point, clipped to the largest positive element
  localparam longint ONE_L = (FRAC_BITS < ELEM_WIDTH - 1) ?
                             (64'sd1 <<< FRAC_BITS) :
                             ((64'sd1 <<< (ELEM_WIDTH - 1)) - 64'sd1);
  localparam logic [ELEM_WIDTH-1:0] ELEM_ONE = ELEM_WIDTH'(ONE_L);

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;
  typedef logic signed [COF_W-1:0]      cof_t;
  typedef logic signed [DET_W-1:0]      det_t;
  typedef logic [FIELD_W-1:0]           field_t;

  // cofactor k (row-major, flat index 3*row+col) = a[P0]*a[P1] - a[S0]*a[S1]
  localparam int CF_OP [N_ELEM][4] = '{
    '{4, 8, 5, 7},
    '{5, 6, 3, 8},
    '{3, 7, 4, 6},
    '{2, 7, 1, 8},
    '{0, 8, 2, 6},
    '{1, 6, 0, 7},
    '{1, 5, 2, 4},
    '{2, 3, 0, 5},
    '{0, 4, 1, 3}
  };
endpackage
`default_nettype wire

// File: sv/mi3_front.sv
// Front end: input register, nine cofactors and the exact determinant.
`default_nettype none
module mi3_front (
  input  wire logic                           clk,
  input  wire logic [mi3_pkg::FRONT_ST-1:0]   en,
  input  wire mi3_pkg::field_t                in_elem [mi3_pkg::N_ELEM],
  output mi3_pkg::cof_t                       cof     [mi3_pkg::N_ELEM],
  output mi3_pkg::det_t                       det
);
  localparam int EW   = mi3_pkg::ELEM_WIDTH;
  localparam int PL_W = 2 * mi3_pkg::ELEM_WIDTH + 1;

  mi3_pkg::elem_t a_r [mi3_pkg::N_ELEM];
  logic signed [mi3_pkg::PROD_W-1:0] pp_r [mi3_pkg::N_ELEM];
  logic signed [mi3_pkg::PROD_W-1:0] ps_r [mi3_pkg::N_ELEM];
  mi3_pkg::elem_t r0a_r [3];
  mi3_pkg::elem_t r0b_r [3];
  mi3_pkg::cof_t  cof2_r [mi3_pkg::N_ELEM];
  mi3_pkg::cof_t  cof3_r [mi3_pkg::N_ELEM];
  mi3_pkg::cof_t  cof4_r [mi3_pkg::N_ELEM];
  mi3_pkg::cof_t  cof5_r [mi3_pkg::N_ELEM];
  logic signed [PL_W-1:0] pl_r [3];
  logic signed [PL_W-1:0] ph_r [3];
  logic signed [mi3_pkg::DPROD_W-1:0] dp_r [3];
  mi3_pkg::det_t det_r;

  // low bits only, sign-extended
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
        a_r[i] <= mi3_pkg::elem_t'(in_elem[i][EW-1:0]);
      end
    end
  end

  genvar k;
  for (k = 0; k < mi3_pkg::N_ELEM; k++) begin : g_cross
    always_ff @(posedge clk) begin
      if (en[1]) begin
        pp_r[k] <= a_r[4'(mi3_pkg::CF_OP[k][0])] * a_r[4'(mi3_pkg::CF_OP[k][1])];
        ps_r[k] <= a_r[4'(mi3_pkg::CF_OP[k][2])] * a_r[4'(mi3_pkg::CF_OP[k][3])];
      end
      if (en[2]) begin
        cof2_r[k] <= mi3_pkg::COF_W'(pp_r[k]) - mi3_pkg::COF_W'(ps_r[k]);
      end
      if (en[3]) cof3_r[k] <= cof2_r[k];
      if (en[4]) cof4_r[k] <= cof3_r[k];
      if (en[5]) cof5_r[k] <= cof4_r[k];
    end
    assign cof[k] = cof5_r[k];
  end

  // row 0 terms of the determinant, cofactor split into two narrow products
  genvar j;
  for (j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk) begin
      if (en[1]) r0a_r[j] <= a_r[4'(j)];
      if (en[2]) r0b_r[j] <= r0a_r[j];
      if (en[3]) begin
        pl_r[j] <= r0b_r[j] * $signed({1'b0, cof2_r[j][EW-1:0]});
        ph_r[j] <= r0b_r[j] * $signed(cof2_r[j][mi3_pkg::COF_W-1:EW]);
      end
      if (en[4]) begin
        dp_r[j] <= (mi3_pkg::DPROD_W'(ph_r[j]) <<< EW) + mi3_pkg::DPROD_W'(pl_r[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      det_r <= mi3_pkg::DET_W'(dp_r[0]) + mi3_pkg::DET_W'(dp_r[1])
             + mi3_pkg::DET_W'(dp_r[2]);
    end
  end

  assign det = det_r;
endmodule
`default_nettype wire

// File: sv/mi3_lane.sv
// One divider lane: cofactor * 2^(2F) / det, restoring, one quotient bit a stage.
`default_nettype none
module mi3_lane (
  input  wire logic                         clk,
  input  wire logic [mi3_pkg::LANE_ST-1:0]  en,
  input  wire mi3_pkg::cof_t                cof,
  input  wire mi3_pkg::det_t                det,
  output mi3_pkg::field_t                   res
);
  localparam int EW    = mi3_pkg::ELEM_WIDTH;
  localparam int QW    = mi3_pkg::QUO_W;
  localparam int RW    = mi3_pkg::REM_W;
  localparam int CMP_W = (mi3_pkg::HI_W > mi3_pkg::DET_W) ? mi3_pkg::HI_W : mi3_pkg::DET_W;
  localparam logic [EW-1:0] POS_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] NEG_MAG = {1'b1, {(EW-1){1'b0}}};

  typedef struct packed {
    logic [RW-1:0]                rem;
    logic [QW-1:0]                nlo;
    logic [QW-1:0]                q;
    logic [mi3_pkg::DET_W-1:0]    dmag;
    logic                         neg;
    logic                         ovf;
  } div_t;

  logic [mi3_pkg::COF_W-1:0] cmag;
  logic [mi3_pkg::DET_W-1:0] dmag;
  logic [mi3_pkg::NUM_W-1:0] num_r;
  logic [mi3_pkg::DET_W-1:0] dmag_r;
  logic                      neg_r;
  logic [mi3_pkg::HI_W-1:0]  nhi;
  div_t                      div_r [QW+1];

  assign cmag = cof[mi3_pkg::COF_W-1] ? -cof : cof;
  assign dmag = det[mi3_pkg::DET_W-1] ? -det : det;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      num_r  <= mi3_pkg::NUM_W'(cmag) << (2 * mi3_pkg::FRAC_BITS);
      dmag_r <= dmag;
      neg_r  <= cof[mi3_pkg::COF_W-1] ^ det[mi3_pkg::DET_W-1];
    end
  end

  // quotient at or above 2^(EW-1) saturates either way
  assign nhi = num_r[mi3_pkg::NUM_W-1:QW];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      div_r[0].rem  <= RW'(nhi);
      div_r[0].nlo  <= num_r[QW-1:0];
      div_r[0].q    <= '0;
      div_r[0].dmag <= dmag_r;
      div_r[0].neg  <= neg_r;
      div_r[0].ovf  <= CMP_W'(nhi) >= CMP_W'(dmag_r);
    end
  end

  genvar t;
  for (t = 0; t < QW; t++) begin : g_div
    localparam int B = QW - 1 - t;
    logic [RW:0]   sh;
    logic [RW:0]   df;
    logic          ge;
    logic [QW-1:0] q_nxt;

    assign sh = {div_r[t].rem, div_r[t].nlo[B]};
    assign df = sh - {1'b0, div_r[t].dmag};
    assign ge = sh >= {1'b0, div_r[t].dmag};

    always_comb begin
      q_nxt    = div_r[t].q;
      q_nxt[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (en[2+t]) begin
        div_r[t+1].rem  <= ge ? df[RW-1:0] : sh[RW-1:0];
        div_r[t+1].nlo  <= div_r[t].nlo;
        div_r[t+1].q    <= q_nxt;
        div_r[t+1].dmag <= div_r[t].dmag;
        div_r[t+1].neg  <= div_r[t].neg;
        div_r[t+1].ovf  <= div_r[t].ovf;
      end
    end
  end

  logic [EW-1:0]  mag;
  mi3_pkg::elem_t sres;

  always_comb begin
    if (div_r[QW].ovf) begin
      mag = div_r[QW].neg ? NEG_MAG : POS_MAX;
    end else begin
      mag = {1'b0, div_r[QW].q};
    end
    sres = div_r[QW].neg ? -mag : mag;
  end

  assign res = mi3_pkg::FIELD_W'(sres);
endmodule
`default_nettype wire

// File: sv/matrix_inverse_3x3_top.sv
// Top level of the 3x3 matrix inverse (adjugate over determinant, Q16.16).
// One 3x3 matrix enters per transaction and one inverse leaves per transaction,
// one matrix per clock sustained while out_tready is high. The default widths give
// 6 front stages (input register, 18 element products, cofactor subtract, split
// determinant products, their recombination, the three-term sum), then in each of
// nine divider lanes 2 setup stages and one stage per quotient bit (31), then the
// output register; the per-lane restoring divider makes up most of them. Every stage
// holds its transaction until the next stage can take it, so empty stages keep
// filling while a finished inverse waits at the output. A zero determinant gives
// the identity matrix with out_tuser high. Quotients are truncated toward zero
// and clipped to the signed 32-bit range.
`default_nettype none
`include "matrix_inverse_3x3_top_defines.svh"
module matrix_inverse_3x3_top (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // a_r0c0, a_r1c0, a_r2c0, a_r0c1, a_r1c1, a_r2c1, a_r0c2, a_r1c2, a_r2c2 (32b each)
  input  wire logic [mi3_pkg::N_ELEM*mi3_pkg::FIELD_W-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // inv_r0c0, inv_r1c0, inv_r2c0, inv_r0c1, inv_r1c1, inv_r2c1, inv_r0c2,
  // inv_r1c2, inv_r2c2 (32b each)
  output logic [mi3_pkg::N_ELEM*mi3_pkg::FIELD_W-1:0] out_tdata,
  // singular
  output logic      out_tuser
);
  localparam int NST = mi3_pkg::PIPE_ST;
  localparam int FST = mi3_pkg::FRONT_ST;
  localparam int LST = mi3_pkg::LANE_ST;
  localparam int FW  = mi3_pkg::FIELD_W;

  logic [NST-1:0] v_r, v_nxt;
  logic [NST-1:0] can;

  // stage k loads when it is empty or its content moves on
  always_comb begin
    can[NST-1] = !v_r[NST-1] || out_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      can[k] = !v_r[k] || can[k+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (can[0]) v_nxt[0] = in_tvalid;
    for (int k = 1; k < NST; k++) begin
      if (can[k]) v_nxt[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = can[0];
  assign out_tvalid = v_r[NST-1];

  // transaction fields are column-major, the front end works row-major
  mi3_pkg::field_t in_elem [mi3_pkg::N_ELEM];
  genvar r, c;
  for (r = 0; r < 3; r++) begin : g_row
    for (c = 0; c < 3; c++) begin : g_col
      assign in_elem[3*r+c] = in_tdata[FW*(3*c+r) +: FW];
    end
  end

  mi3_pkg::cof_t   cof [mi3_pkg::N_ELEM];
  mi3_pkg::det_t   det;
  mi3_pkg::field_t lane_res [mi3_pkg::N_ELEM];

  mi3_front u_front (
    .clk     (clk),
    .en      (can[FST-1:0]),
    .in_elem (in_elem),
    .cof     (cof),
    .det     (det)
  );

  // inverse field 3c+r needs cofactor (c, r), which is row-major flat index 3c+r
  genvar f;
  for (f = 0; f < mi3_pkg::N_ELEM; f++) begin : g_lane
    mi3_lane u_lane (
      .clk (clk),
      .en  (can[FST +: LST]),
      .cof (cof[f]),
      .det (det),
      .res (lane_res[f])
    );
  end

  // singular flag rides alongside the lanes
  logic sing_r [LST];
  always_ff @(posedge clk) begin
    if (can[FST]) sing_r[0] <= (det == '0);
    for (int k = 1; k < LST; k++) begin
      if (can[FST+k]) sing_r[k] <= sing_r[k-1];
    end
  end

  // merge: identity on a singular matrix, lane quotients otherwise
  mi3_pkg::field_t out_data_r [mi3_pkg::N_ELEM];
  logic            out_sing_r;

  for (f = 0; f < mi3_pkg::N_ELEM; f++) begin : g_merge
    localparam bit DIAG = (f == 0) || (f == 4) || (f == 8);
    always_ff @(posedge clk) begin
      if (can[NST-1]) begin
        if (sing_r[LST-1]) begin
          out_data_r[f] <= DIAG ? FW'(mi3_pkg::ELEM_ONE) : '0;
        end else begin
          out_data_r[f] <= lane_res[f];
        end
      end
    end
    assign out_tdata[FW*f +: FW] = out_data_r[f];
  end

  always_ff @(posedge clk) begin
    if (can[NST-1]) out_sing_r <= sing_r[LST-1];
  end

  assign out_tuser = out_sing_r;

  `MI3_ASSERT_NOW(a_full_when_blocked, !in_tready, &v_r, "input refused with a bubble in the pipe")
  `MI3_ASSERT_NEXT(a_accept_fills, in_tvalid && in_tready, v_r[0], "accepted matrix not captured")
  `MI3_ASSERT_NOW(a_sing_identity, out_tvalid && out_tuser, (out_tdata[FW-1:0] == FW'(mi3_pkg::ELEM_ONE)) && (out_tdata[2*FW-1:FW] == '0), "singular result is not identity")
endmodule
`default_nettype wire
